// File: rtl/rls_pkg.sv
// Shared types, codes and timing helpers for the RGB LED strip driver.
// Used by rls_pixel_store and the top level rgb_led_strip_driver.
package rls_pkg;

    localparam int MAX_LEDS  = 64;
    localparam int ADDR_W    = $clog2(MAX_LEDS);
    localparam int COUNT_W   = $clog2(MAX_LEDS + 1);
    localparam int PIXEL_W   = 24;
    localparam int BITPTR_W  = 5;
    localparam int TICK_W    = 16;
    localparam int CFG_W     = 16;
    localparam int CFG_IDX_W = 3;
    localparam int CMD_W     = 3;

    // Command codes.
    localparam logic [CMD_W-1:0] CMD_TICK          = 3'd0;
    localparam logic [CMD_W-1:0] CMD_SET_PIXEL     = 3'd1;
    localparam logic [CMD_W-1:0] CMD_SET_ALL       = 3'd2;
    localparam logic [CMD_W-1:0] CMD_SHOW          = 3'd3;
    localparam logic [CMD_W-1:0] CMD_SET_ALL_SHOW  = 3'd4;

    // Register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_NUM_LEDS  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ZERO_HIGH = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_ZERO_LOW  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_ONE_HIGH  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_ONE_LOW   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_LATCH     = 3'd5;

    // Sender phases.
    localparam logic [1:0] PH_IDLE  = 2'd0;
    localparam logic [1:0] PH_HIGH  = 2'd1;
    localparam logic [1:0] PH_LOW   = 2'd2;
    localparam logic [1:0] PH_LATCH = 2'd3;

    localparam logic [BITPTR_W-1:0] TOP_BIT = 5'd23;

    typedef struct packed {
        logic               en;
        logic [ADDR_W-1:0]  addr;
        logic [PIXEL_W-1:0] data;
    } rls_wr_t;

    // Pulse length for one half of a bit; a zero register acts as one tick.
    function automatic logic [TICK_W-1:0] sel_len(input logic bit_val,
                                                  input logic [7:0] one_v,
                                                  input logic [7:0] zero_v);
        logic [7:0] v;
        v = bit_val ? one_v : zero_v;
        return (v == 8'd0) ? TICK_W'(1) : {8'd0, v};
    endfunction

endpackage

// File: rtl/rls_pixel_store.sv
// Pixel colour store: one synchronous memory with a registered read port.
// Per-entry valid bits make unwritten entries read as zero after reset.
// Depends on rls_pkg.
module rls_pixel_store
    import rls_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  rls_wr_t            wr,
    input  logic [ADDR_W-1:0]  rd_addr,
    output logic [PIXEL_W-1:0] rd_word
);

    logic [PIXEL_W-1:0]  mem [MAX_LEDS];
    logic [MAX_LEDS-1:0] valid_reg;
    logic [PIXEL_W-1:0]  rd_data_reg;
    logic                rd_vld_reg;
    logic                fwd_hit_reg;
    logic [PIXEL_W-1:0]  fwd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr.en)
        begin
            mem[wr.addr] <= wr.data;
        end
        rd_data_reg  <= mem[rd_addr];
        fwd_data_reg <= wr.data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg   <= '0;
            rd_vld_reg  <= 1'b0;
            fwd_hit_reg <= 1'b0;
        end
        else
        begin
            if (wr.en)
            begin
                valid_reg[wr.addr] <= 1'b1;
            end
            rd_vld_reg  <= valid_reg[rd_addr];
            fwd_hit_reg <= wr.en && (wr.addr == rd_addr);
        end
    end

    // A write to the entry being read in the same cycle wins over the old data.
    assign rd_word = fwd_hit_reg ? fwd_data_reg :
                     (rd_vld_reg ? rd_data_reg : '0);

endmodule

// File: rtl/rgb_led_strip_driver.sv
// Top level of the RGB LED strip driver: command decode, fill sweep and serial sender.
// Depends on rls_pkg and rls_pixel_store.
//
// Each item is one tick of the strip timing, so a new item can be started every cycle
// while busy is low; its result appears on the result ports, marked by out_valid, in
// the cycle after the item finishes, and must be taken then. set_all and
// set_all_and_show write the store through its single write port, one pixel per
// cycle for each pixel in use (at most 64), with busy high while the rest are
// written; every other item finishes in the cycle it is accepted. The store reads
// as zero after reset through per-entry valid bits, so no clearing pass is needed.
// While a frame is sent, the next pixel is fetched from the store ahead of time,
// while the current one is still on the line.
module rgb_led_strip_driver
    import rls_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    output logic                 busy,
    input  logic [CMD_W-1:0]     command,
    input  logic [ADDR_W-1:0]    pixel_index,
    input  logic [7:0]           red_level,
    input  logic [7:0]           green_level,
    input  logic [7:0]           blue_level,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_data,
    output logic                 out_valid,
    output logic                 data_line,
    output logic                 busy_res,
    output logic                 ignored,
    output logic                 frame_done
);

    logic [COUNT_W-1:0]  led_count_reg;
    logic [7:0]          zero_high_reg, zero_low_reg, one_high_reg, one_low_reg;
    logic [TICK_W-1:0]   latch_reg;

    logic [1:0]          phase_reg, phase_next;
    logic [COUNT_W-1:0]  ptr_reg, ptr_next;
    logic [BITPTR_W-1:0] bit_reg, bit_next;
    logic [PIXEL_W-1:0]  shift_reg, shift_next;
    logic [TICK_W-1:0]   tick_reg, tick_next;

    logic                fill_reg, fill_next;
    logic [ADDR_W-1:0]   fill_ptr_reg, fill_ptr_next;
    logic [CMD_W-1:0]    hold_cmd_reg;
    logic [PIXEL_W-1:0]  hold_grb_reg;

    logic                out_valid_reg, out_valid_next;
    logic                line_reg, line_next;
    logic                busy_res_reg, busy_res_next;
    logic                ignored_reg, ignored_next;
    logic                done_reg, done_next;

    logic                accept, do_work, sending, is_fill, fill_last, finish;
    logic                start_frame;
    logic [CMD_W-1:0]    cur_cmd;
    logic [PIXEL_W-1:0]  cur_grb, in_grb, first_word;
    logic [ADDR_W-1:0]   fill_addr, rd_addr;
    logic [PIXEL_W-1:0]  rd_word;
    logic [COUNT_W-1:0]  num_sat;
    rls_wr_t             wr;

    rls_pixel_store u_store (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr      (wr),
        .rd_addr (rd_addr),
        .rd_word (rd_word)
    );

    assign in_grb  = {green_level, red_level, blue_level};
    assign num_sat = (cfg_data[COUNT_W-1:0] > COUNT_W'(MAX_LEDS)) ?
                     COUNT_W'(MAX_LEDS) : cfg_data[COUNT_W-1:0];

    always_comb
    begin
        accept    = start && !fill_reg;
        do_work   = accept || fill_reg;
        cur_cmd   = fill_reg ? hold_cmd_reg : command;
        cur_grb   = fill_reg ? hold_grb_reg : in_grb;
        sending   = (phase_reg != PH_IDLE);
        is_fill   = !sending && (led_count_reg != '0) &&
                    ((cur_cmd == CMD_SET_ALL) || (cur_cmd == CMD_SET_ALL_SHOW));
        fill_addr = fill_reg ? fill_ptr_reg : '0;
        fill_last = (({1'b0, fill_addr} + COUNT_W'(1)) == led_count_reg);
        finish    = do_work && !(is_fill && !fill_last);

        wr.en   = 1'b0;
        wr.addr = fill_addr;
        wr.data = cur_grb;
        if (do_work && is_fill)
        begin
            wr.en = 1'b1;
        end
        else if (finish && !sending && (cur_cmd == CMD_SET_PIXEL) &&
                 ({1'b0, pixel_index} < led_count_reg))
        begin
            wr.en   = 1'b1;
            wr.addr = pixel_index;
        end

        fill_next     = do_work && is_fill && !fill_last;
        fill_ptr_next = fill_addr + ADDR_W'(1);

        phase_next   = phase_reg;
        ptr_next     = ptr_reg;
        bit_next     = bit_reg;
        shift_next   = shift_reg;
        tick_next    = tick_reg;
        line_next    = line_reg;
        ignored_next = 1'b0;
        done_next    = 1'b0;
        busy_res_next = 1'b0;
        start_frame  = 1'b0;
        first_word   = rd_word;

        if (sending)
        begin
            ignored_next = (cur_cmd != CMD_TICK);
        end
        else
        begin
            case (cur_cmd)
                CMD_TICK:         ignored_next = 1'b0;
                CMD_SET_PIXEL:    ignored_next = !({1'b0, pixel_index} < led_count_reg);
                CMD_SET_ALL:      ignored_next = 1'b0;
                CMD_SHOW:         start_frame  = 1'b1;
                CMD_SET_ALL_SHOW:
                begin
                    start_frame = 1'b1;
                    first_word  = cur_grb;
                end
                default:          ignored_next = 1'b1;
            endcase
        end

        if (start_frame)
        begin
            ptr_next = '0;
            if (led_count_reg != '0)
            begin
                shift_next = first_word;
                bit_next   = TOP_BIT;
                phase_next = PH_HIGH;
                tick_next  = sel_len(first_word[TOP_BIT], one_high_reg, zero_high_reg);
            end
            else
            begin
                phase_next = PH_LATCH;
                tick_next  = (latch_reg == '0) ? TICK_W'(1) : latch_reg;
            end
        end

        if (phase_next != PH_IDLE)
        begin
            busy_res_next = 1'b1;
            line_next     = (phase_next == PH_HIGH);
            tick_next     = tick_next - TICK_W'(1);
            if (tick_next == '0)
            begin
                case (phase_next)
                    PH_HIGH:
                    begin
                        phase_next = PH_LOW;
                        tick_next  = sel_len(shift_next[bit_next], one_low_reg, zero_low_reg);
                    end
                    PH_LOW:
                    begin
                        if (bit_next != '0)
                        begin
                            bit_next   = bit_next - BITPTR_W'(1);
                            phase_next = PH_HIGH;
                            tick_next  = sel_len(shift_next[bit_next], one_high_reg,
                                                 zero_high_reg);
                        end
                        else
                        begin
                            ptr_next = ptr_next + COUNT_W'(1);
                            // The next pixel was fetched while this one was sent.
                            if (ptr_next < led_count_reg)
                            begin
                                shift_next = rd_word;
                                bit_next   = TOP_BIT;
                                phase_next = PH_HIGH;
                                tick_next  = sel_len(rd_word[TOP_BIT], one_high_reg,
                                                     zero_high_reg);
                            end
                            else
                            begin
                                phase_next = PH_LATCH;
                                tick_next  = (latch_reg == '0) ? TICK_W'(1) : latch_reg;
                            end
                        end
                    end
                    PH_LATCH:
                    begin
                        phase_next = PH_IDLE;
                        done_next  = 1'b1;
                    end
                    default:
                    begin
                        phase_next = PH_IDLE;
                    end
                endcase
            end
        end
        else
        begin
            line_next = 1'b0;
        end

        if (!finish)
        begin
            phase_next = phase_reg;
            ptr_next   = ptr_reg;
            bit_next   = bit_reg;
            shift_next = shift_reg;
            tick_next  = tick_reg;
            line_next  = line_reg;
        end
        out_valid_next = finish;

        // Idle: keep entry zero ready for a show. Sending: fetch the pixel after this one.
        rd_addr = (phase_next == PH_IDLE) ? '0 : (ptr_next[ADDR_W-1:0] + ADDR_W'(1));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            led_count_reg <= '0;
            zero_high_reg <= 8'd20;
            zero_low_reg  <= 8'd42;
            one_high_reg  <= 8'd40;
            one_low_reg   <= 8'd22;
            latch_reg     <= 16'd15000;
            phase_reg     <= PH_IDLE;
            ptr_reg       <= '0;
            bit_reg       <= '0;
            shift_reg     <= '0;
            tick_reg      <= '0;
            line_reg      <= 1'b0;
            fill_reg      <= 1'b0;
            fill_ptr_reg  <= '0;
            out_valid_reg <= 1'b0;
            busy_res_reg  <= 1'b0;
            ignored_reg   <= 1'b0;
            done_reg      <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    REG_NUM_LEDS:  led_count_reg <= num_sat;
                    REG_ZERO_HIGH: zero_high_reg <= cfg_data[7:0];
                    REG_ZERO_LOW:  zero_low_reg  <= cfg_data[7:0];
                    REG_ONE_HIGH:  one_high_reg  <= cfg_data[7:0];
                    REG_ONE_LOW:   one_low_reg   <= cfg_data[7:0];
                    REG_LATCH:     latch_reg     <= cfg_data;
                    default:       ;
                endcase
            end
            phase_reg     <= phase_next;
            ptr_reg       <= ptr_next;
            bit_reg       <= bit_next;
            shift_reg     <= shift_next;
            tick_reg      <= tick_next;
            line_reg      <= line_next;
            fill_reg      <= fill_next;
            fill_ptr_reg  <= fill_ptr_next;
            out_valid_reg <= out_valid_next;
            busy_res_reg  <= busy_res_next;
            ignored_reg   <= ignored_next;
            done_reg      <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            hold_cmd_reg <= command;
            hold_grb_reg <= in_grb;
        end
    end

    assign busy       = fill_reg;
    assign out_valid  = out_valid_reg;
    assign data_line  = line_reg;
    assign busy_res   = busy_res_reg;
    assign ignored    = ignored_reg;
    assign frame_done = done_reg;

endmodule

// File: rtl/rls_checker.sv
// Port-level checks for rgb_led_strip_driver, attached with a bind statement.
// Sees only the top level's ports; no package needed.
module rls_checker (
    input logic clk,
    input logic rst_n,
    input logic busy,
    input logic out_valid,
    input logic data_line,
    input logic busy_res,
    input logic frame_done
);

    // A result never shows while a fill sweep is still running.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !busy)
        else $error("result shown during fill sweep");

    // The end of a fill sweep always delivers its item.
    assert property (@(posedge clk) disable iff (!rst_n)
        $fell(busy) |-> out_valid)
        else $error("fill sweep ended without a result");

    // The last latch tick belongs to the frame and keeps the line low.
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && frame_done) |-> (busy_res && !data_line))
        else $error("frame end with bad line state");

    // Outside a frame the line is low.
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !busy_res) |-> !data_line)
        else $error("line high outside a frame");

endmodule

bind rgb_led_strip_driver rls_checker u_rls_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .busy       (busy),
    .out_valid  (out_valid),
    .data_line  (data_line),
    .busy_res   (busy_res),
    .frame_done (frame_done)
);

// File: tb/sv/tb.sv
`timescale 1ns / 100ps
// Self-checking testbench for rgb_led_strip_driver: drives command items, predicts
// every tick result of the strip sender in place and compares it with the DUT output.
// Depends on rls_pkg and the RTL of rgb_led_strip_driver; reads no files.
module tb;
    import rls_pkg::*;

    localparam logic [CMD_W-1:0]     CMD_BAD_FIRST = 3'd5;
    localparam logic [CMD_W-1:0]     CMD_BAD_LAST  = 3'd7;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_LO  = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_HI  = 3'd7;
    localparam int QUIET_LIMIT  = 2000;
    localparam int ROUND_ITEMS  = 100;
    localparam int PRINT_LIMIT  = 200;

    typedef struct packed {
        logic [CMD_W-1:0]  cmd;
        logic [ADDR_W-1:0] idx;
        logic [7:0]        red;
        logic [7:0]        green;
        logic [7:0]        blue;
    } strip_cmd_t;

    typedef struct packed {
        logic line;
        logic sending;
        logic dropped;
        logic done;
    } tick_result_t;

    logic                 clk = 1'b0;
    logic                 rst_n;
    logic                 start;
    logic                 busy;
    logic [CMD_W-1:0]     command;
    logic [ADDR_W-1:0]    pixel_index;
    logic [7:0]           red_level;
    logic [7:0]           green_level;
    logic [7:0]           blue_level;
    logic                 cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CFG_W-1:0]     cfg_data;
    logic                 out_valid;
    logic                 data_line;
    logic                 busy_res;
    logic                 ignored;
    logic                 frame_done;

    rgb_led_strip_driver DUT (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .busy        (busy),
        .command     (command),
        .pixel_index (pixel_index),
        .red_level   (red_level),
        .green_level (green_level),
        .blue_level  (blue_level),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .out_valid   (out_valid),
        .data_line   (data_line),
        .busy_res    (busy_res),
        .ignored     (ignored),
        .frame_done  (frame_done)
    );

    always #10 clk = ~clk;

    // Predicted copy of the strip state and its registers.
    logic [PIXEL_W-1:0]  px_store [MAX_LEDS];
    logic [1:0]          tx_phase;
    logic [COUNT_W-1:0]  tx_pixel;
    logic [BITPTR_W-1:0] tx_bit;
    logic [PIXEL_W-1:0]  tx_word;
    logic [TICK_W-1:0]   tx_left;
    logic [COUNT_W-1:0]  cfg_num;
    logic [7:0]          cfg_zero_hi, cfg_zero_lo, cfg_one_hi, cfg_one_lo;
    logic [TICK_W-1:0]   cfg_latch;

    strip_cmd_t   pending_cmds [$];
    tick_result_t expected_ticks [$];
    logic         took;
    int           send_gap_pct;
    int           mismatch_count;
    int           quiet_cycles;
    int           sent_items;

    function automatic logic [TICK_W-1:0] half_ticks(input logic [7:0] v);
        return (v == 8'd0) ? TICK_W'(1) : TICK_W'(v);
    endfunction

    function automatic void load_half(input logic [1:0] ph);
        logic b;
        b = tx_word[tx_bit];
        tx_phase = ph;
        if (ph == PH_HIGH)
            tx_left = half_ticks(b ? cfg_one_hi : cfg_zero_hi);
        else
            tx_left = half_ticks(b ? cfg_one_lo : cfg_zero_lo);
    endfunction

    function automatic void load_pixel_or_latch();
        if (tx_pixel < cfg_num)
        begin
            tx_word = px_store[tx_pixel[ADDR_W-1:0]];
            tx_bit  = TOP_BIT;
            load_half(PH_HIGH);
        end
        else
        begin
            tx_phase = PH_LATCH;
            tx_left  = (cfg_latch == '0) ? TICK_W'(1) : cfg_latch;
        end
    endfunction

    function automatic void strip_reset();
        for (int i = 0; i < MAX_LEDS; i++)
            px_store[i] = '0;
        tx_phase    = PH_IDLE;
        tx_pixel    = '0;
        tx_bit      = '0;
        tx_word     = '0;
        tx_left     = '0;
        cfg_num     = '0;
        cfg_zero_hi = 8'd20;
        cfg_zero_lo = 8'd42;
        cfg_one_hi  = 8'd40;
        cfg_one_lo  = 8'd22;
        cfg_latch   = 16'd15000;
    endfunction

    function automatic void strip_set_reg(input logic [CFG_IDX_W-1:0] idx,
                                          input logic [CFG_W-1:0] data);
        case (idx)
            REG_NUM_LEDS:  cfg_num = (data[6:0] > MAX_LEDS) ? COUNT_W'(MAX_LEDS) : data[6:0];
            REG_ZERO_HIGH: cfg_zero_hi = data[7:0];
            REG_ZERO_LOW:  cfg_zero_lo = data[7:0];
            REG_ONE_HIGH:  cfg_one_hi = data[7:0];
            REG_ONE_LOW:   cfg_one_lo = data[7:0];
            REG_LATCH:     cfg_latch = data;
            default:       ;
        endcase
    endfunction

    // One tick of the strip: applies the command, then advances the sender.
    function automatic tick_result_t strip_tick(input strip_cmd_t it);
        tick_result_t res;
        res = '0;
        if (tx_phase != PH_IDLE)
        begin
            res.dropped = (it.cmd != CMD_TICK);
        end
        else
        begin
            case (it.cmd)
                CMD_TICK: ;
                CMD_SET_PIXEL:
                    if (it.idx < cfg_num)
                        px_store[it.idx] = {it.green, it.red, it.blue};
                    else
                        res.dropped = 1'b1;
                CMD_SET_ALL, CMD_SET_ALL_SHOW:
                begin
                    for (int i = 0; i < cfg_num; i++)
                        px_store[i] = {it.green, it.red, it.blue};
                    if (it.cmd == CMD_SET_ALL_SHOW)
                    begin
                        tx_pixel = '0;
                        load_pixel_or_latch();
                    end
                end
                CMD_SHOW:
                begin
                    tx_pixel = '0;
                    load_pixel_or_latch();
                end
                default: res.dropped = 1'b1;
            endcase
        end
        if (tx_phase != PH_IDLE)
        begin
            res.sending = 1'b1;
            res.line    = (tx_phase == PH_HIGH);
            tx_left     = tx_left - 1'b1;
            if (tx_left == '0)
            begin
                case (tx_phase)
                    PH_HIGH: load_half(PH_LOW);
                    PH_LOW:
                        if (tx_bit != '0)
                        begin
                            tx_bit = tx_bit - 1'b1;
                            load_half(PH_HIGH);
                        end
                        else
                        begin
                            tx_pixel = tx_pixel + 1'b1;
                            load_pixel_or_latch();
                        end
                    default:
                    begin
                        tx_phase = PH_IDLE;
                        res.done = 1'b1;
                    end
                endcase
            end
        end
        return res;
    endfunction

    function automatic strip_cmd_t mk_cmd(input logic [CMD_W-1:0] c,
                                          input logic [ADDR_W-1:0] i,
                                          input logic [7:0] r, input logic [7:0] g,
                                          input logic [7:0] b);
        strip_cmd_t it;
        it.cmd   = c;
        it.idx   = i;
        it.red   = r;
        it.green = g;
        it.blue  = b;
        return it;
    endfunction

    function automatic logic [7:0] rand_level();
        case ($urandom_range(0, 7))
            0:       return 8'h00;
            1:       return 8'hFF;
            default: return 8'($urandom);
        endcase
    endfunction

    // Filler while a frame is on the line: mostly plain ticks, some stray commands.
    function automatic strip_cmd_t frame_noise();
        logic [CMD_W-1:0] code;
        if ($urandom_range(0, 9) < 8)
            code = CMD_TICK;
        else
            code = CMD_W'($urandom_range(CMD_SET_PIXEL, CMD_BAD_LAST));
        return mk_cmd(code, ADDR_W'($urandom), 8'($urandom), 8'($urandom), 8'($urandom));
    endfunction

    // Item that fills the store before a show, with some malformed ones mixed in.
    function automatic strip_cmd_t setup_item();
        int               pick;
        logic [CMD_W-1:0] code;
        logic [ADDR_W-1:0] idx;
        pick = $urandom_range(0, 99);
        idx  = ADDR_W'($urandom);
        if (pick < 55 && cfg_num != '0)
        begin
            code = CMD_SET_PIXEL;
            idx  = ADDR_W'($urandom_range(0, cfg_num - 1));
        end
        else if (pick < 65)
            code = CMD_SET_ALL;
        else if (pick < 80)
            code = CMD_TICK;
        else if (pick < 92)
            code = CMD_SET_PIXEL;
        else
            code = CMD_W'($urandom_range(CMD_BAD_FIRST, CMD_BAD_LAST));
        return mk_cmd(code, idx, rand_level(), rand_level(), rand_level());
    endfunction

    // Short strips of at most two pixels keep every frame short.
    function automatic logic [6:0] pick_led_count();
        case ($urandom_range(0, 9))
            0:       return 7'd0;
            1:       return 7'd2;
            default: return 7'd1;
        endcase
    endfunction

    task automatic report_error(input string msg);
        if (mismatch_count < PRINT_LIMIT)
            $display("[%0t] ERROR: %s", $realtime, msg);
        mismatch_count++;
    endtask

    task automatic drain();
        do
            @(posedge clk);
        while (pending_cmds.size() != 0 || expected_ticks.size() != 0);
        repeat (2) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
        @(negedge clk);
        cfg_we    = 1'b1;
        cfg_index = idx;
        cfg_data  = data;
        strip_set_reg(idx, data);
        @(negedge clk);
        cfg_we = 1'b0;
    endtask

    // Keeps feeding ticks until the predicted frame is over. Each batch is a lower
    // bound of the ticks left, so no batch runs past the end of the frame.
    task automatic ride_frame();
        int span;
        int latch_eff;
        drain();
        while (tx_phase != PH_IDLE)
        begin
            latch_eff = (cfg_latch == '0) ? 1 : int'(cfg_latch);
            case (tx_phase)
                PH_HIGH: span = int'(tx_left) + 1 + 2 * int'(tx_bit) + latch_eff;
                PH_LOW:  span = int'(tx_left) + 2 * int'(tx_bit) + latch_eff;
                default: span = int'(tx_left);
            endcase
            repeat (span) pending_cmds.push_back(frame_noise());
            drain();
        end
    endtask

    task automatic random_round();
        int n;
        drain();
        if ($urandom_range(0, 1))
            write_reg(REG_NUM_LEDS, {9'($urandom), pick_led_count()});
        for (logic [CFG_IDX_W-1:0] r = REG_ZERO_HIGH; r <= REG_ONE_LOW; r++)
            if ($urandom_range(0, 2) == 0)
                write_reg(r, {8'($urandom), 8'($urandom_range(0, 2))});
        if ($urandom_range(0, 2) == 0)
            write_reg(REG_LATCH, CFG_W'($urandom_range(0, 8)));
        if ($urandom_range(0, 9) == 0)
            write_reg($urandom_range(0, 1) ? REG_SPARE_HI : REG_SPARE_LO, CFG_W'($urandom));
        n = $urandom_range(2, 8);
        repeat (n) pending_cmds.push_back(setup_item());
        if ($urandom_range(0, 1) != 0)
        begin
            pending_cmds.push_back(mk_cmd($urandom_range(0, 2) ? CMD_SHOW : CMD_SET_ALL_SHOW,
                                          ADDR_W'($urandom), rand_level(), rand_level(),
                                          rand_level()));
            // Now and then a register changes partway through, often while the frame is still on the line.
            if ($urandom_range(0, 3) == 0)
            begin
                repeat ($urandom_range(1, 20)) pending_cmds.push_back(frame_noise());
                drain();
                write_reg(CFG_IDX_W'($urandom_range(REG_NUM_LEDS, REG_LATCH)),
                          CFG_W'($urandom_range(0, 2)));
            end
            ride_frame();
        end
    endtask

    // Takes the presented item when the DUT accepts it and books its expected result.
    always @(posedge clk)
    begin : accept_items
        took = 1'b0;
        if (rst_n && start && !busy)
        begin
            expected_ticks.push_back(strip_tick(pending_cmds[0]));
            pending_cmds.delete(0);
            took = 1'b1;
            sent_items++;
        end
    end

    always @(negedge clk)
    begin : drive_items
        if (!rst_n)
            ;
        else if (start && !took)
            ;
        else if (pending_cmds.size() != 0 && $urandom_range(0, 99) >= send_gap_pct)
        begin
            start       = 1'b1;
            command     = pending_cmds[0].cmd;
            pixel_index = pending_cmds[0].idx;
            red_level   = pending_cmds[0].red;
            green_level = pending_cmds[0].green;
            blue_level  = pending_cmds[0].blue;
        end
        else
        begin
            start = 1'b0;
        end
    end

    always @(posedge clk)
    begin : check_results
        tick_result_t want;
        if (rst_n && out_valid !== 1'b0)
        begin
            if (expected_ticks.size() == 0)
            begin
                report_error("result with no item outstanding");
            end
            else
            begin
                want = expected_ticks.pop_front();
                if (data_line !== want.line)
                    report_error($sformatf("data_line %b, want %b", data_line, want.line));
                if (busy_res !== want.sending)
                    report_error($sformatf("busy_res %b, want %b", busy_res, want.sending));
                if (ignored !== want.dropped)
                    report_error($sformatf("ignored %b, want %b", ignored, want.dropped));
                if (frame_done !== want.done)
                    report_error($sformatf("frame_done %b, want %b", frame_done, want.done));
            end
        end
    end

    always @(posedge clk)
    begin : watchdog
        if ((start && !busy) || out_valid)
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("== FAIL ==");
            $finish;
        end
    end

    initial
    begin : stimulus
        int ph;
        int base_items;
        rst_n          = 1'b0;
        start          = 1'b0;
        command        = CMD_TICK;
        pixel_index    = '0;
        red_level      = '0;
        green_level    = '0;
        blue_level     = '0;
        cfg_we         = 1'b0;
        cfg_index      = REG_NUM_LEDS;
        cfg_data       = '0;
        took           = 1'b0;
        send_gap_pct   = 7;
        mismatch_count = 0;
        quiet_cycles   = 0;
        sent_items     = 0;
        strip_reset();
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(posedge clk);

        // Empty strip after reset: every set_pixel is out of range.
        pending_cmds.push_back(mk_cmd(CMD_TICK, '0, 8'h00, 8'h00, 8'h00));
        pending_cmds.push_back(mk_cmd(CMD_SET_PIXEL, '0, 8'hFF, 8'hFF, 8'hFF));
        for (int c = CMD_BAD_FIRST; c <= CMD_BAD_LAST; c++)
            pending_cmds.push_back(mk_cmd(CMD_W'(c), 6'h3F, 8'h55, 8'hAA, 8'h0F));
        pending_cmds.push_back(mk_cmd(CMD_SET_ALL, '0, 8'hFF, 8'hFF, 8'hFF));
        drain();

        // A count above the store size saturates; spare indexes do nothing.
        write_reg(REG_NUM_LEDS, 16'hFFFF);
        write_reg(REG_SPARE_LO, 16'hFFFF);
        write_reg(REG_SPARE_HI, 16'h0001);
        pending_cmds.push_back(mk_cmd(CMD_SET_ALL, '0, 8'hFF, 8'hFF, 8'hFF));
        pending_cmds.push_back(mk_cmd(CMD_SET_PIXEL, 6'h3F, 8'h00, 8'hFF, 8'h00));
        pending_cmds.push_back(mk_cmd(CMD_SET_PIXEL, '0, 8'h3C, 8'hA5, 8'h0F));
        drain();

        // One pixel with every length register at zero, which counts as one tick.
        write_reg(REG_NUM_LEDS, 16'd1);
        write_reg(REG_ZERO_HIGH, 16'd0);
        write_reg(REG_ZERO_LOW, 16'd0);
        write_reg(REG_ONE_HIGH, 16'd0);
        write_reg(REG_ONE_LOW, 16'd0);
        write_reg(REG_LATCH, 16'd0);
        pending_cmds.push_back(mk_cmd(CMD_SET_ALL_SHOW, '0, 8'hA5, 8'h3C, 8'h81));
        ride_frame();
        pending_cmds.push_back(mk_cmd(CMD_SET_PIXEL, '0, 8'h42, 8'h81, 8'h24));
        pending_cmds.push_back(mk_cmd(CMD_SHOW, '0, 8'h00, 8'h00, 8'h00));
        ride_frame();

        // Bit length registers keep only the low byte of a write.
        write_reg(REG_ZERO_HIGH, 16'hFF01);
        write_reg(REG_ZERO_LOW, 16'h0102);
        write_reg(REG_ONE_HIGH, 16'hFF02);
        write_reg(REG_ONE_LOW, 16'h8001);
        write_reg(REG_LATCH, 16'd3);
        pending_cmds.push_back(mk_cmd(CMD_SET_PIXEL, '0, 8'h0F, 8'hF0, 8'hC3));
        pending_cmds.push_back(mk_cmd(CMD_SHOW, '0, 8'h00, 8'h00, 8'h00));
        ride_frame();

        // With no pixels in use, a show sends only the latch period.
        write_reg(REG_NUM_LEDS, 16'd0);
        write_reg(REG_LATCH, 16'd1);
        pending_cmds.push_back(mk_cmd(CMD_SHOW, '0, 8'h00, 8'h00, 8'h00));
        pending_cmds.push_back(mk_cmd(CMD_TICK, '0, 8'h00, 8'h00, 8'h00));
        pending_cmds.push_back(mk_cmd(CMD_SET_ALL_SHOW, '0, 8'hFF, 8'hFF, 8'hFF));
        ride_frame();

        // Shrinking the strip and a bit length in the middle of a frame.
        write_reg(REG_NUM_LEDS, 16'd3);
        write_reg(REG_ZERO_HIGH, 16'd1);
        write_reg(REG_ZERO_LOW, 16'd2);
        write_reg(REG_ONE_HIGH, 16'd2);
        write_reg(REG_ONE_LOW, 16'd1);
        write_reg(REG_LATCH, 16'd4);
        pending_cmds.push_back(mk_cmd(CMD_SET_ALL, '0, 8'h96, 8'h69, 8'hC3));
        pending_cmds.push_back(mk_cmd(CMD_SHOW, '0, 8'h00, 8'h00, 8'h00));
        repeat (30) pending_cmds.push_back(mk_cmd(CMD_TICK, '0, 8'h00, 8'h00, 8'h00));
        drain();
        write_reg(REG_NUM_LEDS, 16'd1);
        write_reg(REG_ZERO_HIGH, 16'd5);
        ride_frame();

        // Random rounds: items are held back seldom, then often, then never.
        base_items = sent_items;
        for (ph = 0; ph < 3; ph++)
        begin
            case (ph)
                0:       send_gap_pct = 7;
                1:       send_gap_pct = 49;
                default: send_gap_pct = 0;
            endcase
            while (sent_items < base_items + ROUND_ITEMS * (ph + 1))
                random_round();
        end

        drain();
        repeat (100) @(posedge clk);
        if (mismatch_count == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule

// File: rgb_led_strip_driver.f
rtl/rls_pkg.sv
rtl/rls_pixel_store.sv
rtl/rgb_led_strip_driver.sv
rtl/rls_checker.sv
tb/sv/tb.sv
